FILE: sv/rgb2hsv_pkg.sv
package rgb2hsv_pkg;

    localparam int ChanW = 8;
    localparam int QuotW = 16;
    localparam int HueDenW = 11;
    localparam int BitsPerStage = 2;
    localparam int DivStages = QuotW / BitsPerStage;
    localparam int FrontStages = 3;
    localparam int Latency = FrontStages + DivStages;

    typedef struct packed {
        logic [ChanW-1:0] red_in;
        logic [ChanW-1:0] green_in;
        logic [ChanW-1:0] blue_in;
    } t_rgb;

    typedef struct packed {
        logic [QuotW-1:0] hue_out;
        logic [QuotW-1:0] sat_out;
        logic [ChanW-1:0] value_out;
    } t_hsv;

    typedef enum logic [1:0] {
        K_ZERO         = 2'd0,
        K_NEG_ONE      = 2'd1,
        K_NEG_THIRD    = 2'd2,
        K_TWO_THIRDS   = 2'd3
    } t_koff;

    typedef struct packed {
        logic [HueDenW-1:0] hue_rem;
        logic [HueDenW-1:0] hue_den;
        logic [QuotW-1:0]   hue_q;
        logic [ChanW-1:0]   sat_rem;
        logic [QuotW-1:0]   sat_num;
        logic [ChanW-1:0]   sat_den;
        logic [QuotW-1:0]   sat_q;
        logic [ChanW-1:0]   value;
    } t_div;

endpackage

FILE: sv/rgb2hsv_front.sv
module rgb2hsv_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  rgb2hsv_pkg::t_rgb    i_pixel,
    output logic                 o_valid,
    output rgb2hsv_pkg::t_div    o_stage
);

    localparam int W = rgb2hsv_pkg::ChanW;
    localparam int HW = rgb2hsv_pkg::HueDenW;
    localparam int QW = rgb2hsv_pkg::QuotW;
    localparam int NW = 13;

    logic                 r_s1_valid, n_s1_valid;
    logic [W-1:0]         r_s1_max, n_s1_max;
    logic [W-1:0]         r_s1_mid, n_s1_mid;
    logic [W-1:0]         r_s1_low, n_s1_low;
    rgb2hsv_pkg::t_koff   r_s1_k, n_s1_k;

    logic                 r_s2_valid;
    logic [W-1:0]         r_s2_max, n_s2_max;
    logic [W-1:0]         r_s2_c, n_s2_c;
    logic signed [W:0]    r_s2_d, n_s2_d;
    rgb2hsv_pkg::t_koff   r_s2_k;

    logic                 r_s3_valid;
    rgb2hsv_pkg::t_div    r_s3, n_s3;

    logic [W-1:0]         g1, b1, mn;
    rgb2hsv_pkg::t_koff   k1;
    logic [HW-1:0]        c6, c4, c2;
    logic signed [NW-1:0] kc, num, mag_full;
    logic [W+QW-1:0]      sat_n;

    always_comb begin
        g1 = i_pixel.green_in;
        b1 = i_pixel.blue_in;
        k1 = rgb2hsv_pkg::K_ZERO;
        if (i_pixel.green_in < i_pixel.blue_in) begin
            g1 = i_pixel.blue_in;
            b1 = i_pixel.green_in;
            k1 = rgb2hsv_pkg::K_NEG_ONE;
        end
        n_s1_valid = i_valid;
        n_s1_max = i_pixel.red_in;
        n_s1_mid = g1;
        n_s1_low = b1;
        n_s1_k = k1;
        if (i_pixel.red_in < g1) begin
            n_s1_max = g1;
            n_s1_mid = i_pixel.red_in;
            n_s1_k = (k1 == rgb2hsv_pkg::K_ZERO) ? rgb2hsv_pkg::K_NEG_THIRD
                                                 : rgb2hsv_pkg::K_TWO_THIRDS;
        end
    end

    always_comb begin
        mn = (r_s1_mid < r_s1_low) ? r_s1_mid : r_s1_low;
        n_s2_max = r_s1_max;
        n_s2_c = r_s1_max - mn;
        n_s2_d = $signed({1'b0, r_s1_mid}) - $signed({1'b0, r_s1_low});
    end

    always_comb begin
        c4 = {1'b0, r_s2_c, 2'b00};
        c2 = {2'b00, r_s2_c, 1'b0};
        c6 = c4 + c2;
        case (r_s2_k)
            rgb2hsv_pkg::K_ZERO:       kc = '0;
            rgb2hsv_pkg::K_NEG_ONE:    kc = -$signed({2'b00, c6});
            rgb2hsv_pkg::K_NEG_THIRD:  kc = -$signed({2'b00, c2});
            rgb2hsv_pkg::K_TWO_THIRDS: kc = $signed({2'b00, c4});
            default:                   kc = '0;
        endcase
        num = kc + NW'(r_s2_d);
        mag_full = (num < 0) ? -num : num;
        sat_n = {r_s2_c, {QW{1'b0}}} - {{QW{1'b0}}, r_s2_c};

        n_s3.hue_rem = mag_full[HW-1:0];
        n_s3.hue_den = (r_s2_c == '0) ? {HW{1'b1}} : c6;
        n_s3.hue_q = '0;
        n_s3.sat_rem = sat_n[W+QW-1:QW];
        n_s3.sat_num = sat_n[QW-1:0];
        n_s3.sat_den = (r_s2_max == '0) ? {W{1'b1}} : r_s2_max;
        n_s3.sat_q = '0;
        n_s3.value = r_s2_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_max <= n_s1_max;
        r_s1_mid <= n_s1_mid;
        r_s1_low <= n_s1_low;
        r_s1_k <= n_s1_k;
        r_s2_max <= n_s2_max;
        r_s2_c <= n_s2_c;
        r_s2_d <= n_s2_d;
        r_s2_k <= r_s1_k;
        r_s3 <= n_s3;
    end

    assign o_valid = r_s3_valid;
    assign o_stage = r_s3;

endmodule

FILE: sv/rgb2hsv_div_step.sv
module rgb2hsv_div_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  rgb2hsv_pkg::t_div    i_stage,
    output logic                 o_valid,
    output rgb2hsv_pkg::t_div    o_stage
);

    localparam int W = rgb2hsv_pkg::ChanW;
    localparam int HW = rgb2hsv_pkg::HueDenW;
    localparam int QW = rgb2hsv_pkg::QuotW;

    logic                 r_valid;
    rgb2hsv_pkg::t_div    r_stage, n_stage;
    logic [HW:0]          hue_t;
    logic [W:0]           sat_t;

    always_comb begin
        n_stage = i_stage;
        hue_t = '0;
        sat_t = '0;
        for (int i = 0; i < rgb2hsv_pkg::BitsPerStage; i++) begin
            hue_t = {n_stage.hue_rem, 1'b0};
            if (hue_t >= {1'b0, n_stage.hue_den}) begin
                hue_t = hue_t - {1'b0, n_stage.hue_den};
                n_stage.hue_q = {n_stage.hue_q[QW-2:0], 1'b1};
            end else begin
                n_stage.hue_q = {n_stage.hue_q[QW-2:0], 1'b0};
            end
            n_stage.hue_rem = hue_t[HW-1:0];

            sat_t = {n_stage.sat_rem, n_stage.sat_num[QW-1]};
            n_stage.sat_num = {n_stage.sat_num[QW-2:0], 1'b0};
            if (sat_t >= {1'b0, n_stage.sat_den}) begin
                sat_t = sat_t - {1'b0, n_stage.sat_den};
                n_stage.sat_q = {n_stage.sat_q[QW-2:0], 1'b1};
            end else begin
                n_stage.sat_q = {n_stage.sat_q[QW-2:0], 1'b0};
            end
            n_stage.sat_rem = sat_t[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: sv/rgb_to_hsv_convert_unit.sv
// Pipeline: an accepted transaction passes through 3 front stages and 8 divider stages, each
// registered, before its result shows on o_hsv with o_done high.
// Throughput: one transaction per cycle while busy is low; the two restoring dividers retire two
// quotient bits per stage, so every stage takes a new pixel each clock.
// Reset: synchronous, active low; clears all valid bits and holds busy high for its duration.
// The receiver cannot stall: each result is on o_hsv for exactly one cycle.
module rgb_to_hsv_convert_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rgb2hsv_pkg::t_rgb    i_pixel,
    output logic                 o_done,
    output rgb2hsv_pkg::t_hsv    o_hsv
);

    localparam int Stages = rgb2hsv_pkg::DivStages;

    logic                 r_busy;
    logic                 accept;
    logic                 stage_valid [Stages+1];
    rgb2hsv_pkg::t_div    stage_data [Stages+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;
    assign accept = start && !r_busy;

    rgb2hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_pixel (i_pixel),
        .o_valid (stage_valid[0]),
        .o_stage (stage_data[0])
    );

    for (genvar s = 0; s < Stages; s++) begin : g_div
        rgb2hsv_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[s]),
            .i_stage (stage_data[s]),
            .o_valid (stage_valid[s+1]),
            .o_stage (stage_data[s+1])
        );
    end

    assign o_done = stage_valid[Stages];
    assign o_hsv.hue_out = stage_data[Stages].hue_q;
    assign o_hsv.sat_out = stage_data[Stages].sat_q;
    assign o_hsv.value_out = stage_data[Stages].value;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(rgb2hsv_pkg::Latency) o_done)
        else $error("result missing after accepted transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##(rgb2hsv_pkg::Latency) !o_done)
        else $error("result without accepted transaction");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hsv.value_out == '0) |-> (o_hsv.sat_out == '0 && o_hsv.hue_out == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule
